>>> rtl/mieu_pkg.sv
// ----------------------------------------------------------------------------
// mieu_pkg
// Shared types, operation codes and command structs of the integer execute unit.
// ----------------------------------------------------------------------------
package mieu_pkg;

    localparam int RegCount = 32;
    localparam int RegIdxW  = 5;
    localparam int DataW    = 32;

    localparam logic [4:0] OP_ADD  = 5'd0;
    localparam logic [4:0] OP_ADDI = 5'd1;
    localparam logic [4:0] OP_SUB  = 5'd2;
    localparam logic [4:0] OP_AND  = 5'd3;
    localparam logic [4:0] OP_OR   = 5'd4;
    localparam logic [4:0] OP_XOR  = 5'd5;
    localparam logic [4:0] OP_SLT  = 5'd6;
    localparam logic [4:0] OP_SLL  = 5'd7;
    localparam logic [4:0] OP_ROTR = 5'd8;
    localparam logic [4:0] OP_MULT = 5'd9;
    localparam logic [4:0] OP_DIV  = 5'd10;
    localparam logic [4:0] OP_MFHI = 5'd11;
    localparam logic [4:0] OP_MFLO = 5'd12;
    localparam logic [4:0] OP_BEQ  = 5'd13;
    localparam logic [4:0] OP_BNE  = 5'd14;
    localparam logic [4:0] OP_BGTZ = 5'd15;
    localparam logic [4:0] OP_BLEZ = 5'd16;
    localparam logic [4:0] OP_JUMP = 5'd17;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    typedef struct packed {
        logic [4:0]         kind;
        logic [4:0]         dest_reg;
        logic [4:0]         src_a_reg;
        logic [4:0]         src_b_reg;
        logic signed [15:0] immediate;
        logic [4:0]         shift_amount;
        logic [31:0]        jump_target;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        program_counter;
        logic               write_valid;
        logic [4:0]         write_index;
        logic signed [31:0] write_data;
    } t_out_item;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture item, read operands
        logic exec;      // ALU and branch ops, set up multiply and divide
        logic iter;      // one multiply or divide step
        logic finish;    // commit results and fill output register
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic multi;     // current op needs the iterative unit
    } t_dp_sts;

endpackage

>>> rtl/mieu_ctrl.sv
// ----------------------------------------------------------------------------
// mieu_ctrl
// Sequencer: load, execute, optional 32 iteration steps, finish.
// ----------------------------------------------------------------------------
module mieu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_out_busy,
    input  mieu_pkg::t_dp_sts i_sts,
    output mieu_pkg::t_dp_cmd o_cmd
);
    import mieu_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_ITER = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state, n_state;
    logic [4:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_cnt = '0;
                n_state = i_sts.multi ? S_ITER : S_FIN;
            end
            S_ITER: begin
                o_cmd.iter = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) n_state = S_FIN;
            end
            S_FIN: begin
                // Wait until the output register is free.
                if (!i_out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

>>> rtl/mieu_dp.sv
// ----------------------------------------------------------------------------
// mieu_dp
// Datapath: register file, HI/LO/PC, ALU and radix-2 multiply/divide unit.
// ----------------------------------------------------------------------------
module mieu_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mieu_pkg::t_in_item  i_item,
    input  mieu_pkg::t_dp_cmd   i_cmd,
    output mieu_pkg::t_dp_sts   o_sts,
    output mieu_pkg::t_out_item o_res
);
    import mieu_pkg::*;

    logic [31:0] r_gpr [RegCount];
    logic [31:0] r_hi, r_lo, r_pc;
    t_in_item    r_it;
    logic [31:0] r_a, r_b;

    // Result staging.
    logic [1:0]  r_st;
    logic        r_wr;
    logic [31:0] r_val;

    // Iterative unit: r_acc is the running remainder or high product,
    // r_q holds the dividend/quotient or multiplier/low product.
    logic [32:0] r_acc;
    logic [31:0] r_q, r_m;
    logic        r_neg_q, r_neg_r;

    logic [31:0] imm_x, sum, dif, rot, ma, mb;
    logic        is_mult, is_div;
    logic [32:0] trial, addm;
    logic [63:0] prod, prod_n;
    logic [31:0] q_fix, r_fix;

    assign imm_x   = {{16{r_it.immediate[15]}}, r_it.immediate};
    assign is_mult = (r_it.kind == OP_MULT);
    assign is_div  = (r_it.kind == OP_DIV) && (r_b != '0);
    assign o_sts.multi = is_mult || is_div;
    assign sum = r_a + ((r_it.kind == OP_ADDI) ? imm_x : r_b);
    assign dif = r_a - r_b;
    assign rot = (r_it.shift_amount == '0) ? r_a
               : ((r_a >> r_it.shift_amount) | (r_a << (6'd32 - {1'b0, r_it.shift_amount})));
    assign ma  = r_a[31] ? (32'd0 - r_a) : r_a;
    assign mb  = r_b[31] ? (32'd0 - r_b) : r_b;

    assign trial = {r_acc[31:0], r_q[31]} - {1'b0, r_m};
    assign addm  = {1'b0, r_acc[31:0]} + (r_q[0] ? {1'b0, r_m} : 33'd0);
    assign prod  = {r_acc[31:0], r_q};
    assign prod_n = r_neg_q ? (64'd0 - prod) : prod;
    assign q_fix = r_neg_q ? (32'd0 - r_q) : r_q;
    assign r_fix = r_neg_r ? (32'd0 - r_acc[31:0]) : r_acc[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi <= '0;
            r_lo <= '0;
            r_pc <= '0;
            for (int i = 0; i < RegCount; i++) r_gpr[i] <= '0;
        end else begin
            if (i_cmd.load) begin
                r_it <= i_item;
                r_a  <= r_gpr[i_item.src_a_reg];
                r_b  <= r_gpr[i_item.src_b_reg];
            end
            if (i_cmd.exec) begin
                r_st  <= ST_OK;
                r_wr  <= 1'b0;
                r_val <= '0;
                r_acc <= '0;
                r_m   <= mb;
                r_q   <= is_mult ? ma : ma;
                r_neg_q <= r_a[31] ^ r_b[31];
                r_neg_r <= r_a[31];
                case (r_it.kind)
                    OP_ADD, OP_ADDI: begin
                        if ((r_a[31] ^ sum[31]) &&
                            (((r_it.kind == OP_ADDI) ? imm_x[31] : r_b[31]) ^ sum[31]))
                            r_st <= ST_OVF;
                        else begin
                            r_wr <= 1'b1; r_val <= sum;
                        end
                    end
                    OP_SUB: begin
                        if ((r_a[31] ^ r_b[31]) && (r_a[31] ^ dif[31])) r_st <= ST_OVF;
                        else begin
                            r_wr <= 1'b1; r_val <= dif;
                        end
                    end
                    OP_AND:  begin r_wr <= 1'b1; r_val <= r_a & r_b; end
                    OP_OR:   begin r_wr <= 1'b1; r_val <= r_a | r_b; end
                    OP_XOR:  begin r_wr <= 1'b1; r_val <= r_a ^ r_b; end
                    OP_SLT:  begin
                        r_wr <= 1'b1;
                        r_val <= {31'd0, $signed(r_a) < $signed(r_b)};
                    end
                    OP_SLL:  begin r_wr <= 1'b1; r_val <= r_a << r_it.shift_amount; end
                    OP_ROTR: begin r_wr <= 1'b1; r_val <= rot; end
                    OP_DIV:  if (r_b == '0) r_st <= ST_DIV0;
                    OP_MFHI: begin r_wr <= 1'b1; r_val <= r_hi; end
                    OP_MFLO: begin r_wr <= 1'b1; r_val <= r_lo; end
                    OP_BEQ:  if (r_a == r_b) r_pc <= r_pc + imm_x;
                    OP_BNE:  if (r_a != r_b) r_pc <= r_pc + imm_x;
                    OP_BGTZ: if (!r_a[31] && r_a != '0) r_pc <= r_pc + imm_x;
                    OP_BLEZ: if (r_a[31] || r_a == '0) r_pc <= r_pc + imm_x;
                    OP_JUMP: r_pc <= r_it.jump_target;
                    default: ;
                endcase
            end
            if (i_cmd.iter) begin
                if (is_mult) begin
                    // Shift-add: low product bits move into r_q from the top.
                    r_acc <= {1'b0, addm[32:1]};
                    r_q   <= {addm[0], r_q[31:1]};
                end else if (!trial[32]) begin
                    r_acc <= {1'b0, trial[31:0]};
                    r_q   <= {r_q[30:0], 1'b1};
                end else begin
                    r_acc <= {1'b0, r_acc[30:0], r_q[31]};
                    r_q   <= {r_q[30:0], 1'b0};
                end
            end
            if (i_cmd.finish) begin
                if (is_mult) begin
                    r_hi <= prod_n[63:32];
                    r_lo <= prod_n[31:0];
                end else if (is_div) begin
                    r_lo <= q_fix;
                    r_hi <= r_fix;
                end
                if (r_wr) r_gpr[r_it.dest_reg] <= r_val;
            end
        end
    end

    always_comb begin
        o_res.status          = r_st;
        o_res.program_counter = r_pc;
        o_res.write_valid     = r_wr;
        o_res.write_index     = r_wr ? r_it.dest_reg : '0;
        o_res.write_data      = r_wr ? r_val : '0;
    end

endmodule

>>> rtl/mieu_outreg.sv
// ----------------------------------------------------------------------------
// mieu_outreg
// Output register that holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module mieu_outreg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  mieu_pkg::t_out_item i_res,
    output logic                o_busy,
    output logic                o_valid,
    input  logic                i_stall,
    output mieu_pkg::t_out_item o_res
);
    import mieu_pkg::*;

    logic      r_valid;
    t_out_item r_res;

    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_busy  = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_res <= i_res;
    end

endmodule

>>> rtl/mips_integer_execute_unit_core.sv
// ----------------------------------------------------------------------------
// mips_integer_execute_unit_core
// Integer execute unit with register file, HI/LO and program counter.
// ----------------------------------------------------------------------------
// Usage:
// One decoded instruction enters on the input channel (i_in_valid, o_in_stall,
// i_in_item) and one result item leaves on the output channel (o_out_valid,
// i_out_stall, o_out_item) for every accepted item.
// Flow: an accepted item is loaded into the datapath, executed, and its
// result is committed and loaded into the output register; mult and div
// first pass through the radix-2 shift-add and restoring-divide unit, which
// does one bit per cycle. One item is worked on at a time, so the input
// takes a new item in the cycle after the previous result is loaded.
// A finished result waits in the output register while the next item is
// accepted; if the receiver stalls, the next result waits in the sequencer.
// Reset clears the register file, HI, LO, the program counter and all
// handshake state.
// ----------------------------------------------------------------------------
module mips_integer_execute_unit_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mieu_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mieu_pkg::t_out_item o_out_item
);
    import mieu_pkg::*;

    t_dp_cmd   cmd;
    t_dp_sts   sts;
    t_out_item res;
    logic      out_busy;

    mieu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_out_busy (out_busy),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mieu_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_item),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_res   (res)
    );

    mieu_outreg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (cmd.finish),
        .i_res   (res),
        .o_busy  (out_busy),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (o_out_item)
    );

endmodule

>>> rtl/mieu_checker.sv
// ----------------------------------------------------------------------------
// mieu_checker
// Port-level checks of the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module mieu_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input mieu_pkg::t_out_item o_out_item,
    input logic                o_out_valid,
    input logic                i_out_stall
);
    import mieu_pkg::*;

    // Nothing is held after reset.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("state not cleared by reset");

    // An accepted item keeps the input closed for the next cycle.
    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while busy");

    // Write fields are zero unless a register is written.
    a_wr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.write_valid |->
            o_out_item.write_index == '0 && o_out_item.write_data == '0)
        else $error("write fields set without a write");

    // Overflow and divide-by-zero never write a register.
    a_err_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_OK |-> !o_out_item.write_valid)
        else $error("write reported with an error status");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

endmodule

bind mips_integer_execute_unit_core mieu_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_item  (o_out_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall)
);

>>> test/mips_integer_execute_unit_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_integer_execute_unit_core_tb
// Checks every result item of the integer execute unit against a predictor
// that tracks its own copy of the register file, HI, LO and the program
// counter. Directed corner cases come first, then random instruction mixes
// with and without random idling on both channels, and one long receiver hold-off.
// ----------------------------------------------------------------------------
module mips_integer_execute_unit_core_tb;
    import mieu_pkg::*;

    localparam logic [4:0] OP_UNKNOWN = 5'd31;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    mips_integer_execute_unit_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // Predictor state.
    logic [31:0] gpr_model [32];
    logic [31:0] hi_model;
    logic [31:0] lo_model;
    logic [31:0] pc_model;

    t_out_item  pending_results [$];
    int         error_count;
    bit         sender_idles;
    bit         receiver_idles;
    bit         hold_receiver;
    int         hold_cycles;
    int         stall_left;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_out_item execute_instruction(t_in_item ins);
        t_out_item   res;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] imm;
        logic [31:0] opb;
        logic [31:0] sum;
        logic [31:0] val;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] prod;
        logic [31:0] quo;
        logic [31:0] rem_v;
        logic        wr;
        logic [1:0]  st;
        a   = gpr_model[ins.src_a_reg];
        b   = gpr_model[ins.src_b_reg];
        imm = {{16{ins.immediate[15]}}, ins.immediate};
        wr  = 1'b0;
        val = '0;
        st  = ST_OK;
        case (ins.kind)
            OP_ADD, OP_ADDI, OP_SUB: begin
                opb = (ins.kind == OP_ADDI) ? imm : b;
                if (ins.kind == OP_SUB) begin
                    sum = a - opb;
                    st = (((a ^ opb) & (a ^ sum)) >> 31) ? ST_OVF : ST_OK;
                end else begin
                    sum = a + opb;
                    st = (((a ^ sum) & (opb ^ sum)) >> 31) ? ST_OVF : ST_OK;
                end
                if (st == ST_OK) begin
                    wr = 1'b1;
                    val = sum;
                end
            end
            OP_AND: begin wr = 1'b1; val = a & b; end
            OP_OR:  begin wr = 1'b1; val = a | b; end
            OP_XOR: begin wr = 1'b1; val = a ^ b; end
            OP_SLT: begin wr = 1'b1; val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0; end
            OP_SLL: begin wr = 1'b1; val = a << ins.shift_amount; end
            OP_ROTR: begin
                wr = 1'b1;
                val = 32'({a, a} >> ins.shift_amount);
            end
            OP_MULT: begin
                prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                hi_model = prod[63:32];
                lo_model = prod[31:0];
            end
            OP_DIV: begin
                if (b == 0) begin
                    st = ST_DIV0;
                end else begin
                    ma = a[31] ? -a : a;
                    mb = b[31] ? -b : b;
                    quo = ma / mb;
                    rem_v = ma % mb;
                    if (a[31] != b[31]) quo = -quo;
                    if (a[31]) rem_v = -rem_v;
                    lo_model = quo;
                    hi_model = rem_v;
                end
            end
            OP_MFHI: begin wr = 1'b1; val = hi_model; end
            OP_MFLO: begin wr = 1'b1; val = lo_model; end
            OP_BEQ:  if (a == b) pc_model = pc_model + imm;
            OP_BNE:  if (a != b) pc_model = pc_model + imm;
            OP_BGTZ: if (!a[31] && a != 0) pc_model = pc_model + imm;
            OP_BLEZ: if (a[31] || a == 0) pc_model = pc_model + imm;
            OP_JUMP: pc_model = ins.jump_target;
            default: ;
        endcase
        if (wr) gpr_model[ins.dest_reg] = val;
        res.status          = st;
        res.program_counter = pc_model;
        res.write_valid     = wr;
        res.write_index     = wr ? ins.dest_reg : 5'd0;
        res.write_data      = wr ? val : 32'd0;
        return res;
    endfunction

    // Valid stays high into the next item unless the sender idles first.
    task automatic send_instruction(t_in_item ins);
        if (sender_idles && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_in_item  <= ins;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(execute_instruction(ins));
        @(negedge i_clk);
    endtask

    function automatic t_in_item make_instruction(logic [4:0] kind, logic [4:0] rd,
                                                  logic [4:0] ra, logic [4:0] rb,
                                                  logic [15:0] imm, logic [4:0] sh,
                                                  logic [31:0] tgt);
        t_in_item ins;
        ins.kind = kind; ins.dest_reg = rd; ins.src_a_reg = ra; ins.src_b_reg = rb;
        ins.immediate = imm; ins.shift_amount = sh; ins.jump_target = tgt;
        return ins;
    endfunction

    function automatic t_in_item random_instruction();
        t_in_item ins;
        logic [4:0] k;
        ins.dest_reg     = 5'($urandom);
        ins.src_a_reg    = 5'($urandom);
        ins.src_b_reg    = 5'($urandom);
        ins.shift_amount = 5'($urandom);
        ins.jump_target  = $urandom;
        ins.immediate    = 16'($urandom);
        k = 5'($urandom_range(0, 19));
        ins.kind = (k > OP_JUMP) ? 5'($urandom_range(18, 31)) : k;
        // Small immediates make overflow-free addi chains that build values.
        if ($urandom_range(0, 3) == 0) ins.immediate = 16'($urandom_range(0, 8));
        return ins;
    endfunction

    // Checker: compares each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time,
                         o_out_item);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (want.status !== o_out_item.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, o_out_item.status);
                    error_count++;
                end
                if (want.program_counter !== o_out_item.program_counter) begin
                    $display("%0t: pc expected %h actual %h", $time,
                             want.program_counter, o_out_item.program_counter);
                    error_count++;
                end
                if (want.write_valid !== o_out_item.write_valid) begin
                    $display("%0t: write_valid expected %b actual %b", $time,
                             want.write_valid, o_out_item.write_valid);
                    error_count++;
                end
                if (want.write_index !== o_out_item.write_index) begin
                    $display("%0t: write_index expected %0d actual %0d", $time,
                             want.write_index, o_out_item.write_index);
                    error_count++;
                end
                if (want.write_data !== o_out_item.write_data) begin
                    $display("%0t: write_data expected %h actual %h", $time,
                             want.write_data, o_out_item.write_data);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall: random bursts, or a long counted hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_cycles = 0;
            stall_left  = 0;
        end else if (hold_receiver && hold_cycles < 200) begin
            i_out_stall <= 1'b1;
            hold_cycles++;
        end else if (!receiver_idles) begin
            i_out_stall <= 1'b0;
            stall_left  = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= (stall_left != 0);
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  = $urandom_range(1, 10);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic test_corner_values();
        // Seed registers: 2 = min, 3 = -1, 4 = 1; both writes to 1 overflow, so 1 stays 0.
        send_instruction(make_instruction(OP_ADDI, 5'd4, 5'd0, 5'd0, 16'd1, 5'd0, 32'd0));
        send_instruction(make_instruction(OP_ADDI, 5'd3, 5'd0, 5'd0, 16'hFFFF, 5'd0, 32'd0));
        send_instruction(make_instruction(OP_SLL, 5'd2, 5'd4, 5'd0, 16'd0, 5'd31, 32'd0));
        send_instruction(make_instruction(OP_ADD, 5'd1, 5'd2, 5'd3, 16'd0, 5'd0, 32'd0));
        send_instruction(make_instruction(OP_SUB, 5'd1, 5'd2, 5'd4, 16'd0, 5'd0, 32'd0));
        send_instruction(make_instruction(OP_ADD, 5'd5, 5'd2, 5'd2, 16'd0, 5'd0, 32'd0));
        send_instruction(make_instruction(OP_ADDI, 5'd5, 5'd1, 5'd0, 16'd1, 5'd0, 32'd0));
        send_instruction(make_instruction(OP_SLT, 5'd6, 5'd2, 5'd1, 16'd0, 5'd0, 32'd0));
        send_instruction(make_instruction(OP_ROTR, 5'd7, 5'd1, 5'd0, 16'd0, 5'd0, 32'd0));
        send_instruction(make_instruction(OP_ROTR, 5'd7, 5'd4, 5'd0, 16'd0, 5'd31, 32'd0));
        send_instruction(make_instruction(OP_MULT, 5'd0, 5'd2, 5'd2, 16'd0, 5'd0, 32'd0));
        send_instruction(make_instruction(OP_MFHI, 5'd8, 5'd0, 5'd0, 16'd0, 5'd0, 32'd0));
        send_instruction(make_instruction(OP_DIV, 5'd0, 5'd2, 5'd3, 16'd0, 5'd0, 32'd0));
        send_instruction(make_instruction(OP_MFLO, 5'd9, 5'd0, 5'd0, 16'd0, 5'd0, 32'd0));
        send_instruction(make_instruction(OP_DIV, 5'd0, 5'd2, 5'd10, 16'd0, 5'd0, 32'd0));
        send_instruction(make_instruction(OP_MFHI, 5'd9, 5'd0, 5'd0, 16'd0, 5'd0, 32'd0));
        send_instruction(make_instruction(OP_AND, 5'd10, 5'd1, 5'd3, 16'd0, 5'd0, 32'd0));
        send_instruction(make_instruction(OP_OR, 5'd11, 5'd1, 5'd2, 16'd0, 5'd0, 32'd0));
        send_instruction(make_instruction(OP_XOR, 5'd31, 5'd1, 5'd3, 16'd0, 5'd0, 32'd0));
        send_instruction(make_instruction(OP_BEQ, 5'd0, 5'd1, 5'd1, 16'h8000, 5'd0, 32'd0));
        send_instruction(make_instruction(OP_BNE, 5'd0, 5'd1, 5'd2, 16'h7FFF, 5'd0, 32'd0));
        send_instruction(make_instruction(OP_BGTZ, 5'd0, 5'd1, 5'd0, 16'h0010, 5'd0, 32'd0));
        send_instruction(make_instruction(OP_BLEZ, 5'd0, 5'd2, 5'd0, 16'hFFF0, 5'd0, 32'd0));
        send_instruction(make_instruction(OP_JUMP, 5'd0, 5'd0, 5'd0, 16'd0, 5'd0,
                                          32'hFFFFFFFF));
        send_instruction(make_instruction(OP_UNKNOWN, 5'd1, 5'd0, 5'd0, 16'hFFFF, 5'd31,
                                          32'd0));
    endtask

    task automatic test_random_mix(int count);
        repeat (count) send_instruction(random_instruction());
    endtask

    task automatic test_output_backpressure();
        hold_receiver = 1'b1;
        repeat (40) send_instruction(random_instruction());
    endtask

    initial begin
        error_count    = 0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        hold_receiver  = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_item      = '0;
        for (int i = 0; i < 32; i++) gpr_model[i] = '0;
        hi_model = '0;
        lo_model = '0;
        pc_model = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_corner_values();
        test_random_mix(800);
        test_output_backpressure();
        test_random_mix(500);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        test_random_mix(300);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("FAIL");
        $finish;
    end
endmodule
